@@ src/qrpy_pkg.sv @@
package qrpy_pkg;

  // field widths
  localparam int ANGLE_BITS     = 16;
  localparam int QUAT_FRAC_BITS = 14;
  localparam int QUAT_W         = 16;
  localparam int POS_W          = 32;
  localparam int THR_W          = 11;
  localparam logic [THR_W-1:0] THR_RESET = 11'd10;

  // matrix entries, scaled by 2^(2*QUAT_FRAC_BITS)
  localparam int ENTRY_W   = 35;
  localparam int PROD_W    = 2 * QUAT_W;
  localparam int FIT_BITS  = 30;
  localparam int MAX_SHIFT = ENTRY_W - FIT_BITS;
  localparam int SHIFT_W   = 3;

  // shrunk arctangent operands, magnitude below 2^FIT_BITS
  localparam int ATAN_IN_W = FIT_BITS + 1;

  // square root
  localparam int SQ_W     = 2 * ATAN_IN_W;
  localparam int SQ_ITERS = SQ_W / 2;
  localparam int ROOT_W   = SQ_ITERS;

  // cordic
  localparam int CORDIC_ITERS = 30;
  localparam int CORDIC_W     = 34;
  localparam int TURN_W       = 32;
  localparam int CORDIC_IN_W  = 32;
  localparam int UNIT_W       = ANGLE_BITS + 1;

  localparam logic [TURN_W-1:0] ATAN_TURN [0:CORDIC_ITERS-1] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
    32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } pos_t;

  typedef struct packed {
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic signed [QUAT_W-1:0] quat_w;
    logic signed [QUAT_W-1:0] quat_x;
    logic signed [QUAT_W-1:0] quat_y;
    logic signed [QUAT_W-1:0] quat_z;
  } in_word_t;

  typedef struct packed {
    logic signed [POS_W-1:0]      out_x;
    logic signed [POS_W-1:0]      out_y;
    logic signed [POS_W-1:0]      out_z;
    logic signed [ANGLE_BITS-1:0] roll;
    logic signed [ANGLE_BITS-1:0] pitch;
    logic signed [ANGLE_BITS-1:0] yaw;
    logic                         gimbal_lock;
  } out_word_t;

  typedef struct packed {
    pos_t                        pos;
    logic signed [ATAN_IN_W-1:0] a20;
    logic signed [ATAN_IN_W-1:0] a21;
    logic signed [ATAN_IN_W-1:0] a22;
    logic signed [ATAN_IN_W-1:0] b10;
    logic signed [ATAN_IN_W-1:0] b00;
    logic signed [ATAN_IN_W-1:0] c21;
    logic signed [ATAN_IN_W-1:0] c22;
    logic signed [ATAN_IN_W-1:0] d01;
    logic signed [ATAN_IN_W-1:0] d11;
  } item_t;

endpackage

@@ src/qrpy_queue.sv @@
module qrpy_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  qrpy_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output qrpy_pkg::item_t pop_item,
  output logic           empty
);

  qrpy_pkg::item_t mem [0:qrpy_pkg::QUEUE_DEPTH-1];
  logic [qrpy_pkg::QPTR_W-1:0] wr_ptr;
  logic [qrpy_pkg::QPTR_W-1:0] rd_ptr;
  logic [qrpy_pkg::QCNT_W-1:0] count;

  assign full     = (count == qrpy_pkg::QCNT_W'(qrpy_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + qrpy_pkg::QCNT_W'(push) - qrpy_pkg::QCNT_W'(pop);
    end
  end

endmodule

@@ src/qrpy_front.sv @@
module qrpy_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  qrpy_pkg::in_word_t  in_word,
  input  logic                q_full,
  output logic                q_push,
  output qrpy_pkg::item_t     q_item
);

  localparam logic signed [qrpy_pkg::ENTRY_W-1:0] ONE_Q =
    qrpy_pkg::ENTRY_W'(1) <<< (2 * qrpy_pkg::QUAT_FRAC_BITS);
  localparam logic [qrpy_pkg::ENTRY_W-1:0] FIT_LIMIT =
    qrpy_pkg::ENTRY_W'(1) << qrpy_pkg::FIT_BITS;

  function automatic logic [qrpy_pkg::ENTRY_W-1:0] mag(
    input logic signed [qrpy_pkg::ENTRY_W-1:0] v);
    return v[qrpy_pkg::ENTRY_W-1] ? qrpy_pkg::ENTRY_W'(-v) : qrpy_pkg::ENTRY_W'(v);
  endfunction

  function automatic logic [qrpy_pkg::ENTRY_W-1:0] max2(
    input logic [qrpy_pkg::ENTRY_W-1:0] a, input logic [qrpy_pkg::ENTRY_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // smallest shift that brings the magnitude under 2^FIT_BITS
  function automatic logic [qrpy_pkg::SHIFT_W-1:0] fit(
    input logic [qrpy_pkg::ENTRY_W-1:0] m);
    logic [qrpy_pkg::SHIFT_W-1:0] s;
    s = qrpy_pkg::SHIFT_W'(qrpy_pkg::MAX_SHIFT);
    for (int i = qrpy_pkg::MAX_SHIFT; i >= 0; i--) begin
      if ((m >> i) < FIT_LIMIT) begin
        s = qrpy_pkg::SHIFT_W'(i);
      end
    end
    return s;
  endfunction

  // sign kept, magnitude truncated
  function automatic logic signed [qrpy_pkg::ATAN_IN_W-1:0] shrink(
    input logic signed [qrpy_pkg::ENTRY_W-1:0] v, input logic [qrpy_pkg::SHIFT_W-1:0] s);
    logic [qrpy_pkg::ENTRY_W-1:0] m;
    m = mag(v) >> s;
    return v[qrpy_pkg::ENTRY_W-1] ? qrpy_pkg::ATAN_IN_W'(-m) : qrpy_pkg::ATAN_IN_W'(m);
  endfunction

  logic en;
  logic v1, v2, v3, v4;

  qrpy_pkg::pos_t pos1, pos2, pos3;
  logic signed [qrpy_pkg::PROD_W-1:0] p_xx, p_yy, p_zz, p_xy, p_wz, p_xz, p_wy, p_yz, p_wx;
  logic signed [qrpy_pkg::ENTRY_W-1:0] r00, r01, r10, r11, r20, r21, r22;
  logic signed [qrpy_pkg::ENTRY_W-1:0] e00, e01, e10, e11, e20, e21, e22;
  logic [qrpy_pkg::SHIFT_W-1:0] s_p, s_b, s_c, s_d;

  // whole front moves unless its last word is blocked by a full queue
  assign en       = !(v4 && q_full);
  assign in_stall = !en;
  assign q_push   = v4 && !q_full;

  // valid tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // products of quaternion components
  always_ff @(posedge clk) begin
    if (en) begin
      pos1.x <= in_word.pos_x;
      pos1.y <= in_word.pos_y;
      pos1.z <= in_word.pos_z;
      p_xx   <= in_word.quat_x * in_word.quat_x;
      p_yy   <= in_word.quat_y * in_word.quat_y;
      p_zz   <= in_word.quat_z * in_word.quat_z;
      p_xy   <= in_word.quat_x * in_word.quat_y;
      p_wz   <= in_word.quat_w * in_word.quat_z;
      p_xz   <= in_word.quat_x * in_word.quat_z;
      p_wy   <= in_word.quat_w * in_word.quat_y;
      p_yz   <= in_word.quat_y * in_word.quat_z;
      p_wx   <= in_word.quat_w * in_word.quat_x;
    end
  end

  // rotation matrix entries
  always_ff @(posedge clk) begin
    if (en) begin
      pos2 <= pos1;
      r00  <= ONE_Q - ((qrpy_pkg::ENTRY_W'(p_yy) + qrpy_pkg::ENTRY_W'(p_zz)) <<< 1);
      r11  <= ONE_Q - ((qrpy_pkg::ENTRY_W'(p_xx) + qrpy_pkg::ENTRY_W'(p_zz)) <<< 1);
      r22  <= ONE_Q - ((qrpy_pkg::ENTRY_W'(p_xx) + qrpy_pkg::ENTRY_W'(p_yy)) <<< 1);
      r01  <= (qrpy_pkg::ENTRY_W'(p_xy) - qrpy_pkg::ENTRY_W'(p_wz)) <<< 1;
      r10  <= (qrpy_pkg::ENTRY_W'(p_xy) + qrpy_pkg::ENTRY_W'(p_wz)) <<< 1;
      r20  <= (qrpy_pkg::ENTRY_W'(p_xz) - qrpy_pkg::ENTRY_W'(p_wy)) <<< 1;
      r21  <= (qrpy_pkg::ENTRY_W'(p_yz) + qrpy_pkg::ENTRY_W'(p_wx)) <<< 1;
    end
  end

  // common shift for each group of entries
  always_ff @(posedge clk) begin
    if (en) begin
      pos3 <= pos2;
      e00  <= r00;
      e01  <= r01;
      e10  <= r10;
      e11  <= r11;
      e20  <= r20;
      e21  <= r21;
      e22  <= r22;
      s_p  <= fit(max2(mag(r20), max2(mag(r21), mag(r22))));
      s_b  <= fit(max2(mag(r10), mag(r00)));
      s_c  <= fit(max2(mag(r21), mag(r22)));
      s_d  <= fit(max2(mag(r01), mag(r11)));
    end
  end

  // scaled operands into the queue word
  always_ff @(posedge clk) begin
    if (en) begin
      q_item.pos <= pos3;
      q_item.a20 <= shrink(e20, s_p);
      q_item.a21 <= shrink(e21, s_p);
      q_item.a22 <= shrink(e22, s_p);
      q_item.b10 <= shrink(e10, s_b);
      q_item.b00 <= shrink(e00, s_b);
      q_item.c21 <= shrink(e21, s_c);
      q_item.c22 <= shrink(e22, s_c);
      q_item.d01 <= shrink(e01, s_d);
      q_item.d11 <= shrink(e11, s_d);
    end
  end

endmodule

@@ src/qrpy_isqrt.sv @@
module qrpy_isqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [qrpy_pkg::SQ_W-1:0]     v_in,
  output logic [qrpy_pkg::ROOT_W-1:0]   root
);

  localparam int W = qrpy_pkg::SQ_W;
  localparam int N = qrpy_pkg::SQ_ITERS;

  logic [W-1:0] rem_q [0:N-1];
  logic [W-1:0] res_q [0:N-1];

  // one result bit per stage, from the top
  for (genvar j = 0; j < N; j++) begin : g_step
    localparam logic [W-1:0] BITV = W'(1) << (2 * (N - 1 - j));
    logic [W-1:0] v_prev, r_prev;
    logic [W:0]   trial;

    if (j == 0) begin : g_first
      assign v_prev = v_in;
      assign r_prev = '0;
    end else begin : g_next
      assign v_prev = rem_q[j-1];
      assign r_prev = res_q[j-1];
    end

    assign trial = {1'b0, r_prev} + {1'b0, BITV};

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, v_prev} >= trial) begin
          rem_q[j] <= W'({1'b0, v_prev} - trial);
          res_q[j] <= (r_prev >> 1) + BITV;
        end else begin
          rem_q[j] <= v_prev;
          res_q[j] <= r_prev >> 1;
        end
      end
    end
  end

  assign root = res_q[N-1][qrpy_pkg::ROOT_W-1:0];

endmodule

@@ src/qrpy_cordic.sv @@
module qrpy_cordic (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic signed [qrpy_pkg::CORDIC_IN_W-1:0] y_in,
  input  logic signed [qrpy_pkg::CORDIC_IN_W-1:0] x_in,
  output logic [qrpy_pkg::TURN_W-1:0]            z_out
);

  localparam int CW = qrpy_pkg::CORDIC_W;
  localparam int N  = qrpy_pkg::CORDIC_ITERS;
  localparam logic [qrpy_pkg::TURN_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [qrpy_pkg::TURN_W-1:0] THREE_QUARTER_TURN = 32'hC000_0000;

  logic signed [CW-1:0]              x_q [0:N];
  logic signed [CW-1:0]              y_q [0:N];
  logic [qrpy_pkg::TURN_W-1:0]       z_q [0:N];
  logic                              zero_q [0:N];

  // fold the left half plane onto the right
  always_ff @(posedge clk) begin
    if (en) begin
      zero_q[0] <= (x_in == '0) && (y_in == '0);
      if (x_in[qrpy_pkg::CORDIC_IN_W-1]) begin
        if (!y_in[qrpy_pkg::CORDIC_IN_W-1]) begin
          x_q[0] <= CW'(y_in);
          y_q[0] <= -CW'(x_in);
          z_q[0] <= QUARTER_TURN;
        end else begin
          x_q[0] <= -CW'(y_in);
          y_q[0] <= CW'(x_in);
          z_q[0] <= THREE_QUARTER_TURN;
        end
      end else begin
        x_q[0] <= CW'(x_in);
        y_q[0] <= CW'(y_in);
        z_q[0] <= '0;
      end
    end
  end

  // vectoring iterations, one per stage
  for (genvar i = 0; i < N; i++) begin : g_iter
    logic signed [CW-1:0] xs, ys;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        zero_q[i+1] <= zero_q[i];
        if (!y_q[i][CW-1]) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + qrpy_pkg::ATAN_TURN[i];
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - qrpy_pkg::ATAN_TURN[i];
        end
      end
    end
  end

  // zero vector gives angle zero
  assign z_out = zero_q[N] ? '0 : z_q[N];

endmodule

@@ src/qrpy_back.sv @@
module qrpy_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_empty,
  output logic                          q_pop,
  input  qrpy_pkg::item_t               q_item,
  input  logic [qrpy_pkg::THR_W-1:0]    thr,
  output logic                          out_valid,
  input  logic                          out_stall,
  output qrpy_pkg::out_word_t           out_word
);

  localparam int SQN   = qrpy_pkg::SQ_ITERS;
  localparam int CLAT  = qrpy_pkg::CORDIC_ITERS + 1;
  localparam int UW    = qrpy_pkg::UNIT_W;
  localparam int AB    = qrpy_pkg::ANGLE_BITS;
  localparam int RSH   = qrpy_pkg::TURN_W - AB;
  localparam int IW    = qrpy_pkg::CORDIC_IN_W;
  localparam logic signed [UW:0] HALF_PI = (UW + 1)'(1) <<< (AB - 2);

  // turn count to rounded angle units
  function automatic logic signed [UW-1:0] to_units(input logic [qrpy_pkg::TURN_W-1:0] z);
    logic signed [qrpy_pkg::TURN_W:0] a;
    a = $signed({z[qrpy_pkg::TURN_W-1], z}) + ((qrpy_pkg::TURN_W + 1)'(1) <<< (RSH - 1));
    return UW'(a >>> RSH);
  endfunction

  logic en;
  logic v0, v1, v2;
  qrpy_pkg::item_t it0, it1, it2;
  logic signed [qrpy_pkg::SQ_W-1:0] prod21, prod22;
  logic [qrpy_pkg::SQ_W-1:0] sq21, sq22, sumsq;
  logic [qrpy_pkg::ROOT_W-1:0] root;

  qrpy_pkg::item_t dly [0:SQN-1];
  logic            dv  [0:SQN-1];
  qrpy_pkg::pos_t  cpos [0:CLAT-1];
  logic            cv   [0:CLAT-1];

  logic [qrpy_pkg::TURN_W-1:0] z_pitch, z_yaw, z_roll, z_yaw_lock;
  logic signed [UW-1:0] u_pitch, u_yaw, u_roll, u_yaw_lock;
  qrpy_pkg::pos_t u_pos;
  logic           u_v;

  logic [UW-1:0]       abs_pitch;
  logic signed [UW:0]  diff;
  logic [UW:0]         pitch_gap;
  logic                lock;

  assign en    = !out_valid || !out_stall;
  assign q_pop = en && !q_empty;

  // pop, square, sum
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= q_pop;
      v1 <= v0;
      v2 <= v1;
    end
  end

  assign prod21 = it0.a21 * it0.a21;
  assign prod22 = it0.a22 * it0.a22;

  always_ff @(posedge clk) begin
    if (en) begin
      it0   <= q_item;
      it1   <= it0;
      sq21  <= $unsigned(prod21);
      sq22  <= $unsigned(prod22);
      it2   <= it1;
      sumsq <= sq21 + sq22;
    end
  end

  qrpy_isqrt u_isqrt (
    .clk  (clk),
    .en   (en),
    .v_in (sumsq),
    .root (root)
  );

  // word held alongside the square root
  for (genvar k = 0; k < SQN; k++) begin : g_sq_dly
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k] <= 1'b0;
      end else if (en) begin
        dv[k] <= (k == 0) ? v2 : dv[(k == 0) ? 0 : k - 1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dly[k] <= (k == 0) ? it2 : dly[(k == 0) ? 0 : k - 1];
      end
    end
  end

  // four arctangent lanes
  qrpy_cordic u_cordic_pitch (
    .clk   (clk),
    .en    (en),
    .y_in  (-IW'(dly[SQN-1].a20)),
    .x_in  ($signed(IW'(root))),
    .z_out (z_pitch)
  );

  qrpy_cordic u_cordic_yaw (
    .clk   (clk),
    .en    (en),
    .y_in  (IW'(dly[SQN-1].b10)),
    .x_in  (IW'(dly[SQN-1].b00)),
    .z_out (z_yaw)
  );

  qrpy_cordic u_cordic_roll (
    .clk   (clk),
    .en    (en),
    .y_in  (IW'(dly[SQN-1].c21)),
    .x_in  (IW'(dly[SQN-1].c22)),
    .z_out (z_roll)
  );

  qrpy_cordic u_cordic_yaw_lock (
    .clk   (clk),
    .en    (en),
    .y_in  (IW'(dly[SQN-1].d01)),
    .x_in  (IW'(dly[SQN-1].d11)),
    .z_out (z_yaw_lock)
  );

  // position and valid held alongside the cordic lanes
  for (genvar k = 0; k < CLAT; k++) begin : g_c_dly
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[k] <= 1'b0;
      end else if (en) begin
        cv[k] <= (k == 0) ? dv[SQN-1] : cv[(k == 0) ? 0 : k - 1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        cpos[k] <= (k == 0) ? dly[SQN-1].pos : cpos[(k == 0) ? 0 : k - 1];
      end
    end
  end

  // rounding to angle units
  always_ff @(posedge clk) begin
    if (rst) begin
      u_v <= 1'b0;
    end else if (en) begin
      u_v <= cv[CLAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_pos      <= cpos[CLAT-1];
      u_pitch    <= to_units(z_pitch);
      u_yaw      <= to_units(z_yaw);
      u_roll     <= to_units(z_roll);
      u_yaw_lock <= to_units(z_yaw_lock);
    end
  end

  // gimbal lock test: pitch distance from plus or minus pi/2
  always_comb begin
    abs_pitch = u_pitch[UW-1] ? UW'(-u_pitch) : UW'(u_pitch);
    diff      = $signed({1'b0, abs_pitch}) - HALF_PI;
    pitch_gap = diff[UW] ? (UW + 1)'(-diff) : (UW + 1)'(diff);
    lock      = pitch_gap < (UW + 1)'(thr);
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= u_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_word.out_x       <= u_pos.x;
      out_word.out_y       <= u_pos.y;
      out_word.out_z       <= u_pos.z;
      out_word.pitch       <= AB'(u_pitch);
      out_word.roll        <= lock ? '0 : AB'(u_roll);
      out_word.yaw         <= lock ? AB'(-u_yaw_lock) : AB'(u_yaw);
      out_word.gimbal_lock <= lock;
    end
  end

endmodule

@@ src/quaternion_to_roll_pitch_yaw_top.sv @@
// throughput: one word per cycle while in_stall and out_stall are both low;
// 4 front stages, a 4-entry queue, a pop stage,
// 2 square stages, 31 square-root stages, 31 cordic stages per lane, 2 final stages
// reset: synchronous, active high; clears all valid flags and the queue,
// and sets the gimbal threshold to 10
module quaternion_to_roll_pitch_yaw_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  qrpy_pkg::in_word_t            in_word,
  output logic                          out_valid,
  input  logic                          out_stall,
  output qrpy_pkg::out_word_t           out_word,
  input  logic                          cfg_wr_en,
  input  logic [qrpy_pkg::THR_W-1:0]    cfg_wr_data
);

  logic [qrpy_pkg::THR_W-1:0] thr;
  logic                       q_push, q_full, q_pop, q_empty;
  qrpy_pkg::item_t            push_item, pop_item;

  // gimbal threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= qrpy_pkg::THR_RESET;
    end else if (cfg_wr_en) begin
      thr <= cfg_wr_data;
    end
  end

  qrpy_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  qrpy_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  qrpy_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_item    (pop_item),
    .thr       (thr),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
